### sv/snst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snst_pkg
// Shared types, constants and the sigmoid table of the neuron trainer.
// ----------------------------------------------------------------------------
package snst_pkg;

    localparam int NUM_FEATURES = 3;
    localparam int J_W          = $clog2(NUM_FEATURES);
    localparam int FEAT_W       = 16;
    localparam int TGT_W        = 13;
    localparam int W_W          = 24;
    localparam int OUT_W        = 16;
    localparam int ITER_W       = 16;
    localparam int ENTRY_W      = NUM_FEATURES * FEAT_W + TGT_W;
    localparam int TGT_LSB      = NUM_FEATURES * FEAT_W;
    localparam int DOT_W        = FEAT_W + W_W + $clog2(NUM_FEATURES) + 1;

    localparam int SIG_DEPTH = 256;
    localparam int SIG_AW    = $clog2(SIG_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_W0   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W1   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W2   = 2'd3;
    localparam logic [ITER_W-1:0]    ITER_RESET = 16'd1000;
    localparam logic [TGT_W-1:0]     TGT_MAX    = 13'd4096;

    typedef logic [SIG_DEPTH-1:0][OUT_W-1:0] t_sig_tab;

    typedef struct packed {
        logic           st_wr;
        logic           rd_en;
        logic           ld_x_in;
        logic           ld_x_mem;
        logic           dot_en;
        logic           dot_clr;
        logic           lut;
        logic           err_mul;
        logic           dl_mul;
        logic           dl_rnd;
        logic           adj_clr;
        logic           adj_en;
        logic           wu_en;
        logic           sat_clr;
        logic           out_ld;
        logic           out_train;
        logic [J_W-1:0] j;
    } t_cmd;

    localparam longint unsigned Q28_ONE = 64'd1 << 28;

    // restoring long division, only used while the table constant is built
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned dvs);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs}) begin
                rem    = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^f in q28 by a 17 term taylor series
    function automatic longint unsigned exp_q28(input longint unsigned f);
        longint unsigned sum;
        longint unsigned t;
        sum = Q28_ONE;
        t   = Q28_ONE;
        for (int k = 1; k <= 16; k++) begin
            t   = udiv64((t * f) >> 28, 64'(k));
            sum = sum + t;
        end
        return sum;
    endfunction

    // entry i holds sigmoid of the bin midpoint over [-8,8)
    function automatic t_sig_tab build_sig_table();
        t_sig_tab        tab;
        longint unsigned em1;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned n;
        longint unsigned f;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        longint          num;
        em1 = udiv64(64'd1 << 56, exp_q28(Q28_ONE));
        for (int i = 0; i < SIG_DEPTH; i++) begin
            num = 2 * longint'(i) + 1 - longint'(SIG_DEPTH);
            mag = (num < 0) ? longint'(-num) : longint'(num);
            a   = ((64'd8 * mag) << 28) >> SIG_AW;
            n   = a >> 28;
            f   = a & (Q28_ONE - 64'd1);
            e   = udiv64(64'd1 << 56, exp_q28(f));
            for (int m = 0; m < 8; m++) begin
                if (longint'(m) < n) e = (e * em1) >> 28;
            end
            den = Q28_ONE + e;
            if (num > 0) begin
                s = udiv64((64'd1 << 44) + (den >> 1), den);
                if (s > 64'd65535) s = 64'd65535;
            end else begin
                s = udiv64((e << 16) + (den >> 1), den);
            end
            tab[i] = s[OUT_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

### sv/snst_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snst_in_if
// Input channel: training samples and queries.
// ----------------------------------------------------------------------------
interface snst_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic        [12:0] target;
    logic               last_sample;

    modport source(output valid, kind, feature_0, feature_1, feature_2, target,
                   last_sample, input ready);
    modport sink(input valid, kind, feature_0, feature_1, feature_2, target,
                 last_sample, output ready);
endinterface
`default_nettype wire

### sv/snst_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snst_out_if
// Result channel: prediction, weights and training status.
// ----------------------------------------------------------------------------
interface snst_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] prediction;
    logic signed [23:0] weight_0;
    logic signed [23:0] weight_1;
    logic signed [23:0] weight_2;
    logic               from_training;
    logic               saturated;

    modport source(output valid, prediction, weight_0, weight_1, weight_2,
                   from_training, saturated, input ready);
    modport sink(input valid, prediction, weight_0, weight_1, weight_2,
                 from_training, saturated, output ready);
endinterface
`default_nettype wire

### sv/snst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snst_ctrl
// Sequencer: sample count, pass and sample loops, result handshake.
// ----------------------------------------------------------------------------
module snst_ctrl #(
    parameter int MAX_SAMPLES = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_in_valid,
    input  wire                                       i_in_kind,
    input  wire                                       i_in_last,
    output logic                                      o_in_ready,
    input  wire                                       i_out_ready,
    output logic                                      o_out_valid,
    input  wire                                       i_cfg_we,
    input  wire  [snst_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  wire  [snst_pkg::ITER_W-1:0]               i_cfg_iter,
    output snst_pkg::t_cmd                            o_cmd,
    output logic [((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1)-1:0] o_addr
);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);
    localparam logic [snst_pkg::J_W-1:0] J_LAST = snst_pkg::J_W'(snst_pkg::NUM_FEATURES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PASS, S_NEXT, S_LDX, S_DOT, S_LUT, S_E1, S_E2, S_DL,
        S_ADJ, S_WU, S_REPORT
    } t_state;

    t_state                    r_state;
    logic [snst_pkg::J_W-1:0]  r_j;
    logic [CW-1:0]             r_s;
    logic [CW-1:0]             r_count;
    logic [snst_pkg::ITER_W-1:0] r_pass;
    logic [snst_pkg::ITER_W-1:0] r_iter;
    logic                      r_train;
    logic                      r_out_valid;
    logic                      accept;
    logic                      room;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign room        = (r_count < CNT_MAX);

    always_comb begin
        o_cmd   = '0;
        o_cmd.j = r_j;
        o_addr  = r_s[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_addr = r_count[AW-1:0];
                o_cmd.st_wr   = accept && !i_in_kind && room;
                o_cmd.ld_x_in = accept && i_in_kind;
                o_cmd.sat_clr = accept && !i_in_kind && i_in_last;
            end
            S_PASS:  o_cmd.adj_clr = (r_pass != r_iter);
            S_NEXT:  o_cmd.rd_en   = (r_s != r_count);
            S_LDX:   o_cmd.ld_x_mem = 1'b1;
            S_DOT: begin
                o_cmd.dot_en  = 1'b1;
                o_cmd.dot_clr = (r_j == '0);
            end
            S_LUT:   o_cmd.lut     = 1'b1;
            S_E1:    o_cmd.err_mul = 1'b1;
            S_E2:    o_cmd.dl_mul  = 1'b1;
            S_DL:    o_cmd.dl_rnd  = 1'b1;
            S_ADJ:   o_cmd.adj_en  = 1'b1;
            S_WU:    o_cmd.wu_en   = 1'b1;
            S_REPORT: begin
                o_cmd.out_ld    = !r_out_valid || i_out_ready;
                o_cmd.out_train = r_train;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_s         <= '0;
            r_count     <= '0;
            r_pass      <= '0;
            r_iter      <= snst_pkg::ITER_RESET;
            r_train     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == snst_pkg::CFG_ITER) r_iter <= i_cfg_iter;
            if (o_cmd.out_ld) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept && !i_in_kind) begin
                        if (room) r_count <= r_count + 1'b1;
                        if (i_in_last) begin
                            r_train <= 1'b1;
                            r_pass  <= '0;
                            r_state <= S_PASS;
                        end
                    end else if (accept) begin
                        r_train <= 1'b0;
                        r_j     <= '0;
                        r_state <= S_DOT;
                    end
                end
                S_PASS: begin
                    if (r_pass == r_iter) r_state <= S_REPORT;
                    else begin
                        r_s     <= '0;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_j <= '0;
                    if (r_s == r_count) r_state <= S_WU;
                    else r_state <= S_LDX;
                end
                S_LDX: r_state <= S_DOT;
                S_DOT: begin
                    if (r_j == J_LAST) begin
                        r_j     <= '0;
                        r_state <= S_LUT;
                    end else r_j <= r_j + 1'b1;
                end
                S_LUT: r_state <= r_train ? S_E1 : S_REPORT;
                S_E1:  r_state <= S_E2;
                S_E2:  r_state <= S_DL;
                S_DL:  r_state <= S_ADJ;
                S_ADJ: begin
                    if (r_j == J_LAST) begin
                        r_j     <= '0;
                        r_s     <= r_s + 1'b1;
                        r_state <= S_NEXT;
                    end else r_j <= r_j + 1'b1;
                end
                S_WU: begin
                    if (r_j == J_LAST) begin
                        r_j     <= '0;
                        r_pass  <= r_pass + 1'b1;
                        r_state <= S_PASS;
                    end else r_j <= r_j + 1'b1;
                end
                S_REPORT: begin
                    if (o_cmd.out_ld) begin
                        if (r_train) r_count <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/snst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snst_dp
// Datapath: sample memory, shared multiply-accumulate, sigmoid lookup,
// delta, weight update with saturation and the result register.
// ----------------------------------------------------------------------------
module snst_dp #(
    parameter int MAX_SAMPLES = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  snst_pkg::t_cmd                        i_cmd,
    input  wire  [((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1)-1:0] i_addr,
    input  wire  signed [snst_pkg::FEAT_W-1:0]    i_feature_0,
    input  wire  signed [snst_pkg::FEAT_W-1:0]    i_feature_1,
    input  wire  signed [snst_pkg::FEAT_W-1:0]    i_feature_2,
    input  wire  [snst_pkg::TGT_W-1:0]            i_target,
    input  wire                                   i_cfg_we,
    input  wire  [snst_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [snst_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic [snst_pkg::OUT_W-1:0]            o_prediction,
    output logic signed [snst_pkg::W_W-1:0]       o_weight_0,
    output logic signed [snst_pkg::W_W-1:0]       o_weight_1,
    output logic signed [snst_pkg::W_W-1:0]       o_weight_2,
    output logic                                  o_from_training,
    output logic                                  o_saturated
);
    localparam int NF      = snst_pkg::NUM_FEATURES;
    localparam int FW      = snst_pkg::FEAT_W;
    localparam int WW      = snst_pkg::W_W;
    localparam int DW      = snst_pkg::DOT_W;
    localparam int ERR_W   = snst_pkg::OUT_W + 2;
    localparam int P1_W    = 2 * ERR_W;
    localparam int P2_W    = P1_W + ERR_W;
    localparam int DELTA_W = P2_W + 1 - 24;
    localparam int ADJ_W   = FW + DELTA_W + $clog2(MAX_SAMPLES) + 1;
    localparam int RND_W   = ADJ_W + 1 - 20;
    localparam int SUM_W   = ((RND_W > WW) ? RND_W : WW) + 1;
    localparam logic signed [DW-1:0]    LIM    = DW'(33'sh0_8000_0000);
    localparam logic signed [P2_W:0]    D_BIAS = (P2_W + 1)'(25'sh080_0000);
    localparam logic signed [ADJ_W:0]   A_BIAS = (ADJ_W + 1)'(21'sh0_8_0000);
    localparam logic signed [SUM_W-1:0] W_MAX  = SUM_W'($signed(24'h7F_FFFF));
    localparam logic signed [SUM_W-1:0] W_MIN  = SUM_W'($signed(24'h80_0000));

    logic [snst_pkg::ENTRY_W-1:0] mem [MAX_SAMPLES];
    logic [snst_pkg::ENTRY_W-1:0] r_rd;
    logic signed [FW-1:0]         r_x [NF];
    logic [snst_pkg::TGT_W-1:0]   r_tgt;
    logic signed [WW-1:0]         r_w [NF];
    logic signed [DW-1:0]         r_dot;
    logic [snst_pkg::OUT_W-1:0]   r_out;
    logic signed [P1_W-1:0]       r_p1;
    logic signed [P2_W-1:0]       r_p2;
    logic signed [DELTA_W-1:0]    r_delta;
    logic signed [ADJ_W-1:0]      r_adj [NF];
    logic                         r_sat;

    logic [snst_pkg::TGT_W-1:0]   tgt_clamp;
    logic signed [FW+WW-1:0]      mac_prod;
    logic signed [DW-1:0]         dot_sum;
    logic signed [DW-1:0]         dot_off;
    logic [snst_pkg::SIG_AW-1:0]  sig_idx;
    logic signed [ERR_W-1:0]      err;
    logic signed [ERR_W-1:0]      out_s;
    logic signed [ERR_W-1:0]      one_minus;
    logic signed [P2_W:0]         p2_b;
    logic signed [FW+DELTA_W-1:0] adj_prod;
    logic signed [ADJ_W:0]        adj_b;
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [WW-1:0]         w_new;
    logic                         w_clip;

    assign tgt_clamp = (i_target > snst_pkg::TGT_MAX) ? snst_pkg::TGT_MAX : i_target;
    assign mac_prod  = r_x[i_cmd.j] * r_w[i_cmd.j];
    assign dot_sum   = (i_cmd.dot_clr ? DW'(0) : r_dot) + DW'(mac_prod);
    assign dot_off   = r_dot + LIM;

    always_comb begin
        if (r_dot < -LIM) sig_idx = '0;
        else if (r_dot >= LIM) sig_idx = '1;
        else sig_idx = dot_off[31 -: snst_pkg::SIG_AW];
    end

    assign out_s     = $signed({2'b00, r_out});
    assign err       = $signed({1'b0, r_tgt, 4'b0000}) - out_s;
    assign one_minus = $signed(ERR_W'(18'h1_0000)) - out_s;
    assign p2_b      = (P2_W + 1)'(r_p2) + D_BIAS;
    assign adj_prod  = r_x[i_cmd.j] * r_delta;
    assign adj_b     = (ADJ_W + 1)'(r_adj[i_cmd.j]) + A_BIAS;
    assign w_sum     = SUM_W'(r_w[i_cmd.j]) + SUM_W'($signed(adj_b[ADJ_W:20]));

    always_comb begin
        w_clip = 1'b1;
        if (w_sum > W_MAX) w_new = W_MAX[WW-1:0];
        else if (w_sum < W_MIN) w_new = W_MIN[WW-1:0];
        else begin
            w_new  = w_sum[WW-1:0];
            w_clip = 1'b0;
        end
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.st_wr) mem[i_addr] <= {tgt_clamp, i_feature_2, i_feature_1, i_feature_0};
        if (i_cmd.rd_en) r_rd <= mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_x_in) begin
            r_x[0] <= i_feature_0;
            r_x[1] <= i_feature_1;
            r_x[2] <= i_feature_2;
        end else if (i_cmd.ld_x_mem) begin
            for (int k = 0; k < NF; k++) r_x[k] <= $signed(r_rd[k*FW +: FW]);
            r_tgt <= r_rd[snst_pkg::TGT_LSB +: snst_pkg::TGT_W];
        end
        if (i_cmd.dot_en)  r_dot   <= dot_sum;
        if (i_cmd.lut)     r_out   <= snst_pkg::SIG_TABLE[sig_idx];
        if (i_cmd.err_mul) r_p1    <= err * out_s;
        if (i_cmd.dl_mul)  r_p2    <= r_p1 * one_minus;
        if (i_cmd.dl_rnd)  r_delta <= p2_b[P2_W:24];
        if (i_cmd.out_ld) begin
            o_prediction    <= i_cmd.out_train ? '0 : r_out;
            o_weight_0      <= r_w[0];
            o_weight_1      <= r_w[1];
            o_weight_2      <= r_w[2];
            o_from_training <= i_cmd.out_train;
            o_saturated     <= i_cmd.out_train && r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NF; k++) begin
                r_w[k]   <= '0;
                r_adj[k] <= '0;
            end
            r_sat <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    snst_pkg::CFG_W0: r_w[0] <= $signed(i_cfg_data);
                    snst_pkg::CFG_W1: r_w[1] <= $signed(i_cfg_data);
                    snst_pkg::CFG_W2: r_w[2] <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.adj_clr) begin
                for (int k = 0; k < NF; k++) r_adj[k] <= '0;
            end
            if (i_cmd.adj_en) r_adj[i_cmd.j] <= r_adj[i_cmd.j] + ADJ_W'(adj_prod);
            if (i_cmd.wu_en) begin
                r_w[i_cmd.j] <= w_new;
                if (w_clip) r_sat <= 1'b1;
            end
            if (i_cmd.sat_clr) r_sat <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### sv/single_neuron_sigmoid_trainer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// single_neuron_sigmoid_trainer_top
// Three-input sigmoid neuron with stored samples and batch gradient descent.
// ----------------------------------------------------------------------------
// A training sample is taken and stored (up to MAX_SAMPLES, further ones
// are dropped). The sample marked last starts a run of `iterations` passes
// and then one result with the new weights. A pass works through the stored
// samples in turn, and the single shared multiply-accumulate unit walks the
// features one per cycle. A query loads its features, forms the dot product
// feature by feature, looks up the sigmoid and loads the result register
// once it is free. The input is not ready while an item is being worked on;
// a result waits in an output register, so the next item may be taken
// before the last result is read.
module single_neuron_sigmoid_trainer_top #(
    parameter int MAX_SAMPLES = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    snst_in_if.sink                              i_smp,
    snst_out_if.source                           o_res,
    input  wire                                  i_cfg_we,
    input  wire  [snst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [snst_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    snst_pkg::t_cmd cmd;
    logic [AW-1:0]  addr;

    snst_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .i_in_kind   (i_smp.kind),
        .i_in_last   (i_smp.last_sample),
        .o_in_ready  (i_smp.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_iter  (i_cfg_data[snst_pkg::ITER_W-1:0]),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    snst_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .i_feature_0     (i_smp.feature_0),
        .i_feature_1     (i_smp.feature_1),
        .i_feature_2     (i_smp.feature_2),
        .i_target        (i_smp.target),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_prediction    (o_res.prediction),
        .o_weight_0      (o_res.weight_0),
        .o_weight_1      (o_res.weight_1),
        .o_weight_2      (o_res.weight_2),
        .o_from_training (o_res.from_training),
        .o_saturated     (o_res.saturated)
    );

    // a new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_ld |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten");

    // read, dot product, accumulate and update steps run only while the input is held off
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.dot_en || cmd.adj_en || cmd.wu_en || cmd.rd_en) |-> !i_smp.ready)
        else $error("datapath step while input ready");

    // at most one datapath step per cycle
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.rd_en, cmd.ld_x_mem, cmd.dot_en, cmd.lut, cmd.err_mul,
                  cmd.dl_mul, cmd.dl_rnd, cmd.adj_en, cmd.wu_en, cmd.out_ld}))
        else $error("overlapping datapath steps");
endmodule
`default_nettype wire

### test/single_neuron_sigmoid_trainer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_neuron_sigmoid_trainer_top_tb
// Self-checking bench for the sigmoid neuron trainer. A directed table covers
// reset, weight and feature extremes, zero and maximum pass counts, store
// overflow and weight clipping; random sample sets, queries and noise follow.
// Every result is compared field by field with an in-bench neuron model or the table.
// ----------------------------------------------------------------------------
module single_neuron_sigmoid_trainer_top_tb;

    localparam longint CYCLE_LIMIT = 64'd16_000_000;
    localparam int     RAND_ITEMS  = 1800;
    localparam int     SETTLE      = 30;
    localparam longint Q28         = 64'd1 << 28;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] f0;
        logic signed [15:0] f1;
        logic signed [15:0] f2;
        logic        [12:0] tgt;
        logic               last;
    } t_item;

    typedef struct packed {
        logic        [15:0] pred;
        logic signed [23:0] w0;
        logic signed [23:0] w1;
        logic signed [23:0] w2;
        logic               ft;
        logic               sat;
    } t_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op            op;
        logic [snst_pkg::CFG_IDX_W-1:0]  idx;
        logic [snst_pkg::CFG_DATA_W-1:0] data;
        t_item              it;
        int                 reps;
        bit                 typed;
        t_res               exp_res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [snst_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [snst_pkg::CFG_DATA_W-1:0] cfg_data;

    snst_in_if  smp();
    snst_out_if res();

    single_neuron_sigmoid_trainer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // neuron model state
    logic [15:0] sig_lut [256];
    longint      nw [3];
    int          pass_cnt;
    longint      st_x [16][3];
    longint      st_t [16];
    int          st_n;

    t_res   pending_res [$];
    int     n_err;
    int     n_checked;
    int     n_queries;
    int     n_runs;
    int     n_sat_runs;
    longint cycles;
    int     burst_left;
    bit     hold_req;
    t_row   rows [$];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_res.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint unsigned taylor_exp(input longint unsigned f);
        longint unsigned acc;
        longint unsigned term;
        acc  = Q28;
        term = Q28;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * f) >> 28) / longint'(k);
            acc  = acc + term;
        end
        return acc;
    endfunction

    task automatic fill_sigmoid_lut();
        longint unsigned inv_e;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned ip;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        longint          mid;
        inv_e = (64'd1 << 56) / taylor_exp(Q28);
        for (int i = 0; i < 256; i++) begin
            mid = 2 * longint'(i) + 1 - 256;
            mag = (mid < 0) ? -mid : mid;
            a   = ((64'd8 * mag) << 28) / 256;
            ip  = a >> 28;
            e   = (64'd1 << 56) / taylor_exp(a & (Q28 - 1));
            while (ip > 0) begin
                e  = (e * inv_e) >> 28;
                ip = ip - 1;
            end
            den = Q28 + e;
            if (mid > 0) begin
                s = ((64'd1 << 44) + den / 2) / den;
                if (s > 65535) s = 65535;
            end else begin
                s = ((e << 16) + den / 2) / den;
            end
            sig_lut[i] = s[15:0];
        end
    endtask

    // round to nearest, halves up
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint neuron_out(input longint x0, input longint x1,
                                          input longint x2);
        longint dot;
        longint lim;
        dot = x0 * nw[0] + x1 * nw[1] + x2 * nw[2];
        lim = longint'(8) <<< 28;
        if (dot < -lim) return sig_lut[0];
        if (dot >= lim) return sig_lut[255];
        return sig_lut[((dot + lim) * 256) >>> 32];
    endfunction

    function automatic bit train_passes();
        bit     clipped;
        longint adj [3];
        longint o;
        longint d;
        longint w;
        clipped = 1'b0;
        for (int p = 0; p < pass_cnt; p++) begin
            adj = '{0, 0, 0};
            for (int s = 0; s < st_n; s++) begin
                o = neuron_out(st_x[s][0], st_x[s][1], st_x[s][2]);
                d = rnd_shift(((st_t[s] <<< 4) - o) * o * (65536 - o), 24);
                for (int j = 0; j < 3; j++) adj[j] += st_x[s][j] * d;
            end
            for (int j = 0; j < 3; j++) begin
                w = nw[j] + rnd_shift(adj[j], 20);
                if (w > 8388607) begin
                    w = 8388607;
                    clipped = 1'b1;
                end
                if (w < -8388608) begin
                    w = -8388608;
                    clipped = 1'b1;
                end
                nw[j] = w;
            end
        end
        return clipped;
    endfunction

    task automatic model_cfg(input logic [snst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [snst_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            snst_pkg::CFG_ITER: pass_cnt = data[15:0];
            snst_pkg::CFG_W0:   nw[0] = longint'($signed(data));
            snst_pkg::CFG_W1:   nw[1] = longint'($signed(data));
            snst_pkg::CFG_W2:   nw[2] = longint'($signed(data));
            default: ;
        endcase
    endtask

    // updates the model for one accepted item and queues its result, if it has one
    task automatic model_item(input t_item it, input bit typed, input t_res typed_res);
        t_res   r;
        longint t;
        r = '0;
        if (!it.kind) begin
            t = (it.tgt > snst_pkg::TGT_MAX) ? snst_pkg::TGT_MAX : it.tgt;
            if (st_n < 16) begin
                st_x[st_n] = '{it.f0, it.f1, it.f2};
                st_t[st_n] = t;
                st_n++;
            end
            if (!it.last) return;
            r.sat = train_passes();
            st_n  = 0;
            r.ft  = 1'b1;
            n_runs++;
            if (r.sat) n_sat_runs++;
        end else begin
            r.pred = neuron_out(it.f0, it.f1, it.f2);
            n_queries++;
        end
        r.w0 = nw[0][23:0];
        r.w1 = nw[1][23:0];
        r.w2 = nw[2][23:0];
        if (typed) begin
            r.w0  = typed_res.w0;
            r.w1  = typed_res.w1;
            r.w2  = typed_res.w2;
            r.ft  = typed_res.ft;
            r.sat = typed_res.sat;
            if (!it.kind) r.pred = '0;
        end
        pending_res.push_back(r);
    endtask

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        n_err++;
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_res.size() == 0) begin
                report("result with no transaction pending");
            end else begin
                e = pending_res.pop_front();
                n_checked++;
                if (res.prediction !== e.pred)
                    report($sformatf("prediction %0d, want %0d", res.prediction, e.pred));
                if (res.weight_0 !== e.w0)
                    report($sformatf("weight_0 %0d, want %0d", res.weight_0, e.w0));
                if (res.weight_1 !== e.w1)
                    report($sformatf("weight_1 %0d, want %0d", res.weight_1, e.w1));
                if (res.weight_2 !== e.w2)
                    report($sformatf("weight_2 %0d, want %0d", res.weight_2, e.w2));
                if (res.from_training !== e.ft)
                    report($sformatf("from_training %0b, want %0b", res.from_training, e.ft));
                if (res.saturated !== e.sat)
                    report($sformatf("saturated %0b, want %0b", res.saturated, e.sat));
            end
        end
    end

    // receiver: randomly chosen stretches of always ready, random and mostly stalled, plus a long stall on hold_req
    initial begin
        int mode;
        int len;
        res.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(5, 120);
            for (int c = 0; c < len; c++) begin
                if (hold_req) begin
                    res.ready <= 1'b0;
                    repeat (400) @(posedge i_clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= $urandom_range(0, 1);
                    default: res.ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_item it, input bit typed, input t_res typed_res);
        int gap;
        cfg_we <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                smp.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        smp.valid       <= 1'b1;
        smp.kind        <= it.kind;
        smp.feature_0   <= it.f0;
        smp.feature_1   <= it.f1;
        smp.feature_2   <= it.f2;
        smp.target      <= it.tgt;
        smp.last_sample <= it.last;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        burst_left--;
        model_item(it, typed, typed_res);
    endtask

    // wait for every pending result, then let a no-result sample finish
    task automatic drain();
        smp.valid <= 1'b0;
        cfg_we    <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [snst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [snst_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        model_cfg(idx, data);
    endtask

    function automatic t_item mk(input logic k, input int a, input int b, input int c,
                                 input int t, input logic l);
        t_item it;
        it.kind = k;
        it.f0   = a[15:0];
        it.f1   = b[15:0];
        it.f2   = c[15:0];
        it.tgt  = t[12:0];
        it.last = l;
        return it;
    endfunction

    function automatic void add_item(input t_item it, input int reps = 1, input bit typed = 0,
                                     input t_res e = '0);
        t_row r;
        r.op = ROW_ITEM; r.idx = '0; r.data = '0;
        r.it = it; r.reps = reps; r.typed = typed; r.exp_res = e;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [snst_pkg::CFG_IDX_W-1:0] idx,
                                    input int data);
        t_row r;
        r.op = ROW_CFG; r.idx = idx; r.data = data[23:0];
        r.it = '0; r.reps = 1; r.typed = 0; r.exp_res = '0;
        rows.push_back(r);
    endfunction

    function automatic logic [15:0] mid_feat();
        return 16'($urandom_range(0, 16383) - 8192);
    endfunction

    initial begin
        t_item it;
        bit    prev_cfg;
        int    n;
        int    rand_items;
        int    since_cfg;
        int    pick;
        n_err = 0; n_checked = 0; n_queries = 0; n_runs = 0; n_sat_runs = 0;
        cycles = 0; burst_left = 0; hold_req = 0;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_data        <= '0;
        smp.valid       <= 1'b0;
        smp.kind        <= 1'b0;
        smp.feature_0   <= '0;
        smp.feature_1   <= '0;
        smp.feature_2   <= '0;
        smp.target      <= '0;
        smp.last_sample <= 1'b0;
        fill_sigmoid_lut();
        pass_cnt = snst_pkg::ITER_RESET;
        nw = '{0, 0, 0};
        st_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_item(mk(1, 0, 0, 0, 0, 0), 1, 1, '{16'd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0});
        add_item(mk(1, 32767, -32768, 32767, 8191, 1), 1, 1,
                 '{16'd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0});
        add_cfg(snst_pkg::CFG_W0, 8388607);
        add_cfg(snst_pkg::CFG_W1, -8388608);
        add_cfg(snst_pkg::CFG_W2, 1);
        add_item(mk(1, 32767, 32767, 0, 0, 0), 1, 1,
                 '{16'd0, 24'h7fffff, 24'h800000, 24'sd1, 1'b0, 1'b0});
        add_item(mk(1, -32768, 0, 0, 0, 1));
        add_item(mk(1, 32767, 0, -1, 4096, 0));
        add_cfg(snst_pkg::CFG_ITER, 0);
        // no passes: weights come back unchanged
        add_item(mk(0, 100, 200, 300, 8191, 1), 1, 1,
                 '{16'd0, 24'h7fffff, 24'h800000, 24'sd1, 1'b1, 1'b0});
        add_cfg(snst_pkg::CFG_ITER, 1);
        add_cfg(snst_pkg::CFG_W0, 0);
        add_cfg(snst_pkg::CFG_W1, 0);
        add_cfg(snst_pkg::CFG_W2, 0);
        // overflow the store, then end the run on a dropped sample
        add_item(mk(0, 4096, -4096, 2048, 4096, 0), 17);
        add_item(mk(0, -32768, 32767, 0, 0, 1));
        add_cfg(snst_pkg::CFG_ITER, 65535);
        add_item(mk(0, 4096, 0, 0, 0, 1));
        add_item(mk(1, 4096, 0, 0, 0, 0));
        add_cfg(snst_pkg::CFG_ITER, 3);
        add_cfg(snst_pkg::CFG_W0, 8388606);
        add_item(mk(0, 1, 0, 0, 4096, 1));
        add_item(mk(1, 1, 0, 0, 0, 0));

        prev_cfg = 0;
        foreach (rows[r]) begin
            if (rows[r].op == ROW_CFG) begin
                if (!prev_cfg) drain();
                cfg_write(rows[r].idx, rows[r].data);
                prev_cfg = 1;
            end else begin
                for (int k = 0; k < rows[r].reps; k++)
                    send_item(rows[r].it, rows[r].typed, rows[r].exp_res);
                prev_cfg = 0;
            end
        end

        // long receiver hold-off while queries keep coming
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
            send_item(mk(1, mid_feat(), mid_feat(), mid_feat(), 0, 0), 0, '0);

        rand_items = 0;
        since_cfg  = 1000;
        while (rand_items < RAND_ITEMS) begin
            if (since_cfg > 150) begin
                drain();
                cfg_write(snst_pkg::CFG_ITER,
                          24'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6)));
                for (int j = 1; j <= 3; j++)
                    cfg_write(j[snst_pkg::CFG_IDX_W-1:0],
                              24'(($urandom_range(0, 5) == 0) ? $urandom()
                                  : ($urandom_range(0, 1 << 19) - (1 << 18))));
                since_cfg = 0;
            end
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                // well-formed set, sometimes overflowing the store
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                    : $urandom_range(1, 16);
                for (int k = 0; k < n; k++) begin
                    it = mk(0, mid_feat(), mid_feat(), mid_feat(),
                            $urandom_range(0, 4096), k == n - 1);
                    if ($urandom_range(0, 19) == 0) it.tgt = $urandom();
                    send_item(it, 0, '0);
                end
                rand_items += n;
                since_cfg  += n;
            end else if (pick <= 7) begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_item(mk(1, mid_feat(), mid_feat(), mid_feat(), $urandom(),
                                 $urandom_range(0, 1)), 0, '0);
                rand_items += n;
                since_cfg  += n;
            end else if (pick == 8) begin
                it = $urandom();
                if (!it.kind && $urandom_range(0, 1)) it.last = 1'b0;
                send_item(it, 0, '0);
                rand_items++;
                since_cfg++;
            end else begin
                // broken set: samples without an end mark, finished by later items
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    send_item(mk(0, $urandom(), $urandom(), $urandom(), $urandom(), 0),
                              0, '0);
                rand_items += n;
                since_cfg  += n;
            end
        end
        // close any open set
        send_item(mk(0, 0, 0, 0, 2048, 1), 0, '0);
        drain();

        $display("checked %0d results: %0d queries, %0d training runs (%0d with clipping)",
                 n_checked, n_queries, n_runs, n_sat_runs);
        $display("%0d mismatches, %0d results left unmatched", n_err, pending_res.size());
        if (n_err == 0 && pending_res.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
